// ===== design/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants for the block move/compare/IO step
// Field layouts of the input and result beats, op and write codes, flag bits.
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

    localparam int unsigned InTdataW  = 112;
    localparam int unsigned OutTdataW = 120;

    typedef enum logic [1:0] {
        OP_MOVE    = 2'd0,
        OP_COMPARE = 2'd1,
        OP_IN      = 2'd2,
        OP_OUT     = 2'd3
    } t_op_kind;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_MEM  = 2'd1;
    localparam logic [1:0] WR_PORT = 2'd2;

    localparam int unsigned FlC  = 0;
    localparam int unsigned FlN  = 1;
    localparam int unsigned FlPv = 2;
    localparam int unsigned Fl3  = 3;
    localparam int unsigned FlH  = 4;
    localparam int unsigned Fl5  = 5;
    localparam int unsigned FlZ  = 6;
    localparam int unsigned FlS  = 7;

    // half borrow, indexed by {r[3], data[3], a[3]}
    localparam logic [7:0] HalfBorrowTab = 8'b1101_0100;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] memptr_value;
        logic [15:0] pc_value;
        logic [15:0] hl_value;
        logic [15:0] de_value;
        logic [15:0] bc_value;
        logic [7:0]  flags_in;
        logic [7:0]  acc_value;
        logic        repeat_mode;
        logic        go_down;
        logic [1:0]  op_kind;
    } t_step_in;

    typedef struct packed {
        logic [7:0]  write_data;
        logic [15:0] write_address;
        logic [1:0]  write_kind;
        logic [15:0] memptr_out;
        logic [15:0] pc_out;
        logic [15:0] hl_out;
        logic [15:0] de_out;
        logic [15:0] bc_out;
        logic [7:0]  flags_out;
    } t_step_out;

endpackage

`default_nettype wire

// ===== design/bmc_in_reg.sv =====
// ----------------------------------------------------------------------------
// bmc_in_reg: input register stage
// Captures one input beat per cycle; holds it while the next stage stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_in_reg
    import bmc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [InTdataW-1:0]  i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_step_in                  o_step
);

    logic     r_valid;
    t_step_in r_step;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_step  = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_step <= t_step_in'(i_data[$bits(t_step_in)-1:0]);
        end
    end

endmodule

`default_nettype wire

// ===== design/bmc_step.sv =====
// ----------------------------------------------------------------------------
// bmc_step: execute logic for one block instruction step
// Pointer/counter updates, flag rules, repeat test and write request.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_step
    import bmc_pkg::*;
(
    input  wire t_step_in i_step,
    output t_step_out     o_result
);

    logic [15:0] step;
    logic [15:0] hl_n;
    logic [15:0] bc_dec;
    logic [7:0]  b_dec;
    logic [7:0]  c_val;
    logic [7:0]  mv_sum;
    logic [7:0]  cp_diff;
    logic [7:0]  cp_adj;
    logic        cp_h;
    logic [7:0]  io_base;
    logic [8:0]  io_k;
    logic [7:0]  par_src;
    logic        again;
    logic [15:0] pc_back;
    logic [7:0]  f;
    logic [15:0] bc_n;
    logic [15:0] de_n;
    logic [15:0] mp_n;
    logic [1:0]  wkind;
    logic [15:0] waddr;
    logic [7:0]  wdata;

    always_comb begin
        step    = i_step.go_down ? 16'hFFFF : 16'h0001;
        hl_n    = i_step.hl_value + step;
        bc_dec  = i_step.bc_value - 16'd1;
        b_dec   = i_step.bc_value[15:8] - 8'd1;
        c_val   = i_step.bc_value[7:0];
        mv_sum  = i_step.data_byte + i_step.acc_value;
        cp_diff = i_step.acc_value - i_step.data_byte;
        cp_h    = HalfBorrowTab[{cp_diff[3], i_step.data_byte[3], i_step.acc_value[3]}];
        cp_adj  = cp_diff - {7'd0, cp_h};
        io_base = (i_step.op_kind == OP_IN) ? (c_val + step[7:0]) : hl_n[7:0];
        io_k    = {1'b0, io_base} + {1'b0, i_step.data_byte};
        par_src = {b_dec[7:3], io_k[2:0] ^ b_dec[2:0]};
        pc_back = i_step.pc_value - 16'd2;

        f     = '0;
        bc_n  = bc_dec;
        de_n  = i_step.de_value;
        mp_n  = i_step.memptr_value;
        wkind = WR_NONE;
        waddr = '0;
        wdata = '0;
        again = 1'b0;

        case (t_op_kind'(i_step.op_kind))
            OP_MOVE: begin
                f         = i_step.flags_in & 8'hC1;
                f[FlPv]   = (bc_dec != 16'd0);
                f[Fl5]    = mv_sum[1];
                f[Fl3]    = mv_sum[3];
                de_n      = i_step.de_value + step;
                wkind     = WR_MEM;
                waddr     = i_step.de_value;
                wdata     = i_step.data_byte;
                again     = i_step.repeat_mode && (bc_dec != 16'd0);
            end
            OP_COMPARE: begin
                f[FlC]    = i_step.flags_in[FlC];
                f[FlN]    = 1'b1;
                f[FlH]    = cp_h;
                f[FlZ]    = (cp_diff == 8'd0);
                f[FlS]    = cp_diff[7];
                f[FlPv]   = (bc_dec != 16'd0);
                f[Fl5]    = cp_adj[1];
                f[Fl3]    = cp_adj[3];
                mp_n      = i_step.memptr_value + step;
                again     = i_step.repeat_mode && (bc_dec != 16'd0) && (cp_diff != 8'd0);
            end
            default: begin
                // port input / output: B counts, C kept
                bc_n      = {b_dec, c_val};
                f         = b_dec & 8'hA8;
                f[FlZ]    = (b_dec == 8'd0);
                f[FlN]    = i_step.data_byte[7];
                f[FlH]    = io_k[8];
                f[FlC]    = io_k[8];
                f[FlPv]   = ~(^par_src);
                wdata     = i_step.data_byte;
                if (i_step.op_kind == OP_IN) begin
                    mp_n  = i_step.bc_value + step;
                    wkind = WR_MEM;
                    waddr = i_step.hl_value;
                end else begin
                    mp_n  = {b_dec, c_val} + step;
                    wkind = WR_PORT;
                    waddr = {b_dec, c_val};
                end
                again     = i_step.repeat_mode && (b_dec != 8'd0);
            end
        endcase

        o_result.flags_out     = f;
        o_result.bc_out        = bc_n;
        o_result.de_out        = de_n;
        o_result.hl_out        = hl_n;
        o_result.pc_out        = again ? pc_back : i_step.pc_value;
        o_result.memptr_out    = (again && !i_step.op_kind[1]) ? (pc_back + 16'd1) : mp_n;
        o_result.write_kind    = wkind;
        o_result.write_address = waddr;
        o_result.write_data    = wdata;
    end

endmodule

`default_nettype wire

// ===== design/bmc_out_reg.sv =====
// ----------------------------------------------------------------------------
// bmc_out_reg: result register stage
// Holds one result beat; loads a new one whenever it is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_out_reg
    import bmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_step_out             i_result,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OutTdataW-1:0]       o_data
);

    logic      r_valid;
    t_step_out r_result;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {{(OutTdataW - $bits(t_step_out)){1'b0}}, r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== design/block_move_compare_io_step.sv =====
// ----------------------------------------------------------------------------
// Stages: input register, execute logic, result register; results leave on m_axis.
// Throughput: one beat per cycle while m_axis_tready does not hold results back.
// Either stage keeps loading while the stage after it is empty or being drained.
// Reset: i_rst_n synchronous active low, clears both stage valid flags only.
// ----------------------------------------------------------------------------
// block_move_compare_io_step: Z80 block move/compare/IO single step
// Computes new registers, flags and write request for LDx/CPx/INx/OUTx.
// ----------------------------------------------------------------------------
`default_nettype none

module block_move_compare_io_step
    import bmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, low bit up: op_kind[1:0], go_down, repeat_mode, acc_value[7:0],
    // flags_in[7:0], bc_value, de_value, hl_value, pc_value, memptr_value,
    // data_byte[7:0], zero pad to 112
    input  wire logic [InTdataW-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, low bit up: flags_out[7:0], bc_out, de_out, hl_out, pc_out,
    // memptr_out, write_kind[1:0], write_address, write_data[7:0], zero pad to 120
    output logic [OutTdataW-1:0]       m_axis_tdata
);

    logic      ex_valid;
    logic      ex_ready;
    t_step_in  ex_step;
    t_step_out ex_result;

    bmc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (ex_valid),
        .i_ready (ex_ready),
        .o_step  (ex_step)
    );

    bmc_step u_step (
        .i_step   (ex_step),
        .o_result (ex_result)
    );

    bmc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ex_valid),
        .o_ready  (ex_ready),
        .i_result (ex_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for block_move_compare_io_step
// Drives Z80 block move/compare/IO steps into s_axis and checks every result
// beat on m_axis, field by field, against an in-bench model of the step.
// Directed corner cases come first, then random steps under three idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

    import bmc_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int RandomSteps = 345;
    localparam int ShownErrors = 10;
    localparam int DrainCycles = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata, low bit up: op_kind, go_down, repeat_mode, acc_value, flags_in,
    // bc_value, de_value, hl_value, pc_value, memptr_value, data_byte, zero pad
    logic [InTdataW-1:0]  s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata, low bit up: flags_out, bc_out, de_out, hl_out, pc_out, memptr_out,
    // write_kind, write_address, write_data, zero pad
    logic [OutTdataW-1:0] m_axis_tdata;

    int send_idle_pct = 37;
    int recv_idle_pct = 79;
    int steps_sent = 0;
    int steps_checked = 0;
    int error_count = 0;
    int cycle_count = 0;
    int rewind_count = 0;
    int kind_count[4] = '{0, 0, 0, 0};

    t_step_out predicted_steps[$];

    block_move_compare_io_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // One block-instruction step: new registers, flags and the write it makes.
    function automatic t_step_out z80_block_step(input t_step_in s);
        logic [15:0] stp;
        logic [15:0] hl_n;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] pc;
        logic [15:0] mp;
        logic [15:0] waddr;
        logic [7:0]  f;
        logic [7:0]  n;
        logic [7:0]  r;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  cs;
        logic [8:0]  k;
        logic [1:0]  wk;
        logic        h;
        logic        again;
        t_step_out   o;
        stp = s.go_down ? 16'hffff : 16'h0001;
        hl_n = s.hl_value + stp;
        bc = s.bc_value;
        de = s.de_value;
        pc = s.pc_value;
        mp = s.memptr_value;
        wk = WR_NONE;
        waddr = '0;
        f = '0;
        again = 1'b0;
        case (s.op_kind)
            OP_MOVE: begin
                n = s.data_byte + s.acc_value;
                wk = WR_MEM;
                waddr = de;
                de = de + stp;
                bc = bc - 16'd1;
                f[FlS] = s.flags_in[FlS];
                f[FlZ] = s.flags_in[FlZ];
                f[FlC] = s.flags_in[FlC];
                f[FlPv] = (bc != 16'd0);
                f[Fl5] = n[1];
                f[Fl3] = n[3];
                again = s.repeat_mode && (bc != 16'd0);
            end
            OP_COMPARE: begin
                r = s.acc_value - s.data_byte;
                h = (s.acc_value[3:0] < s.data_byte[3:0]);
                bc = bc - 16'd1;
                f[FlC] = s.flags_in[FlC];
                f[FlN] = 1'b1;
                f[FlH] = h;
                f[FlZ] = (r == 8'd0);
                f[FlS] = r[7];
                f[FlPv] = (bc != 16'd0);
                n = r - {7'd0, h};
                f[Fl5] = n[1];
                f[Fl3] = n[3];
                mp = mp + stp;
                again = s.repeat_mode && (bc != 16'd0) && !f[FlZ];
            end
            default: begin
                c = s.bc_value[7:0];
                b = s.bc_value[15:8] - 8'd1;
                if (s.op_kind == OP_IN) begin
                    mp = s.bc_value + stp;
                    wk = WR_MEM;
                    waddr = s.hl_value;
                    cs = c + stp[7:0];
                    k = {1'b0, cs} + {1'b0, s.data_byte};
                end else begin
                    wk = WR_PORT;
                    waddr = {b, c};
                    mp = {b, c} + stp;
                    k = {1'b0, hl_n[7:0]} + {1'b0, s.data_byte};
                end
                bc = {b, c};
                f[FlS] = b[7];
                f[Fl5] = b[5];
                f[Fl3] = b[3];
                f[FlZ] = (b == 8'd0);
                f[FlN] = s.data_byte[7];
                f[FlH] = k[8];
                f[FlC] = k[8];
                f[FlPv] = ~^({5'd0, k[2:0]} ^ b);
                again = s.repeat_mode && (b != 8'd0);
            end
        endcase
        if (again) begin
            pc = pc - 16'd2;
            if (s.op_kind == OP_MOVE || s.op_kind == OP_COMPARE) begin
                mp = pc + 16'd1;
            end
        end
        o.flags_out = f;
        o.bc_out = bc;
        o.de_out = de;
        o.hl_out = hl_n;
        o.pc_out = pc;
        o.memptr_out = mp;
        o.write_kind = wk;
        o.write_address = waddr;
        o.write_data = (s.op_kind == OP_COMPARE) ? 8'd0 : s.data_byte;
        return o;
    endfunction

    function automatic t_step_in step_of(input t_op_kind kind, input logic down,
                                         input logic rep, input logic [7:0] a,
                                         input logic [7:0] f, input logic [15:0] bc,
                                         input logic [15:0] de, input logic [15:0] hl,
                                         input logic [15:0] pc, input logic [15:0] mp,
                                         input logic [7:0] d);
        t_step_in s;
        s.op_kind = kind;
        s.go_down = down;
        s.repeat_mode = rep;
        s.acc_value = a;
        s.flags_in = f;
        s.bc_value = bc;
        s.de_value = de;
        s.hl_value = hl;
        s.pc_value = pc;
        s.memptr_value = mp;
        s.data_byte = d;
        return s;
    endfunction

    // Random step, leaning toward counters near zero, pointer wrap and equal compares.
    function automatic t_step_in rand_step();
        t_step_in s;
        s.op_kind = 2'($urandom_range(3));
        s.go_down = 1'($urandom_range(1));
        s.repeat_mode = 1'($urandom_range(1));
        s.acc_value = 8'($urandom);
        s.flags_in = 8'($urandom);
        s.data_byte = 8'($urandom);
        case ($urandom_range(3))
            0: s.bc_value = 16'($urandom_range(2));
            1: s.bc_value = {8'($urandom_range(2)), 8'($urandom)};
            default: s.bc_value = 16'($urandom);
        endcase
        s.de_value = ($urandom_range(7) == 0) ? {16{1'($urandom_range(1))}} : 16'($urandom);
        s.hl_value = ($urandom_range(7) == 0) ? {16{1'($urandom_range(1))}} : 16'($urandom);
        s.pc_value = ($urandom_range(7) == 0) ? 16'($urandom_range(2)) : 16'($urandom);
        s.memptr_value = 16'($urandom);
        if (s.op_kind == OP_COMPARE && $urandom_range(3) == 0) begin
            s.data_byte = s.acc_value;
        end
        return s;
    endfunction

    // Returns just after the edge where the beat was taken.
    task automatic send_step(input t_step_in s);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tdata <= InTdataW'(s);
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        steps_sent++;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= ShownErrors) begin
                $display("step %0d: %s expected %h got %h", steps_checked, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_step_in  taken;
        t_step_out want;
        t_step_out got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken = t_step_in'(s_axis_tdata[$bits(t_step_in)-1:0]);
                want = z80_block_step(taken);
                predicted_steps.push_back(want);
                kind_count[taken.op_kind]++;
                if (want.pc_out != taken.pc_value) begin
                    rewind_count++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_step_out'(m_axis_tdata[$bits(t_step_out)-1:0]);
                if (predicted_steps.size() == 0) begin
                    error_count++;
                    if (error_count <= ShownErrors) begin
                        $display("unexpected result beat %h", got);
                    end
                end else begin
                    want = predicted_steps.pop_front();
                    check_field("flags_out", 16'(want.flags_out), 16'(got.flags_out));
                    check_field("bc_out", want.bc_out, got.bc_out);
                    check_field("de_out", want.de_out, got.de_out);
                    check_field("hl_out", want.hl_out, got.hl_out);
                    check_field("pc_out", want.pc_out, got.pc_out);
                    check_field("memptr_out", want.memptr_out, got.memptr_out);
                    check_field("write_kind", 16'(want.write_kind), 16'(got.write_kind));
                    check_field("write_address", want.write_address, got.write_address);
                    check_field("write_data", 16'(want.write_data), 16'(got.write_data));
                end
                steps_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d of %0d steps checked",
                     cycle_count, steps_checked, steps_sent);
            $display("block_move_compare_io_step regression: fail");
            $finish;
        end
    end

    task automatic test_move_edges();
        // BC 1 ends the loop; all-ones registers
        send_step(step_of(OP_MOVE, 1'b0, 1'b1, 8'hff, 8'hff, 16'h0001, 16'hffff,
                          16'hffff, 16'h0000, 16'h1234, 8'hff));
        // BC 0 wraps and keeps going, PC wraps below zero
        send_step(step_of(OP_MOVE, 1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000,
                          16'h0000, 16'h0001, 16'h0000, 8'h00));
        send_step(step_of(OP_MOVE, 1'b0, 1'b1, 8'h0a, 8'h55, 16'h1234, 16'h8000,
                          16'h4000, 16'h8000, 16'hffff, 8'h00));
        send_step(step_of(OP_MOVE, 1'b1, 1'b0, 8'h80, 8'haa, 16'hffff, 16'h7fff,
                          16'h8001, 16'hfffe, 16'h5555, 8'h7f));
    endtask

    task automatic test_compare_edges();
        // match stops the repeat
        send_step(step_of(OP_COMPARE, 1'b0, 1'b1, 8'h42, 8'h00, 16'h0005, 16'h1111,
                          16'h2222, 16'h3333, 16'h4444, 8'h42));
        // half borrow, BC wraps, memptr follows the rewound PC
        send_step(step_of(OP_COMPARE, 1'b1, 1'b1, 8'h10, 8'hff, 16'h0000, 16'h0000,
                          16'h0000, 16'h0001, 16'hffff, 8'h01));
        send_step(step_of(OP_COMPARE, 1'b0, 1'b1, 8'h00, 8'hff, 16'h0001, 16'hffff,
                          16'hffff, 16'hffff, 16'h0000, 8'hff));
        send_step(step_of(OP_COMPARE, 1'b1, 1'b0, 8'hff, 8'h00, 16'h8000, 16'h0001,
                          16'h0001, 16'h8000, 16'h8000, 8'h00));
        send_step(step_of(OP_COMPARE, 1'b0, 1'b1, 8'h80, 8'h01, 16'hffff, 16'h5a5a,
                          16'hfffe, 16'h0000, 16'h0000, 8'h7f));
    endtask

    task automatic test_io_edges();
        // input: B goes to zero, C+1 plus data carries
        send_step(step_of(OP_IN, 1'b0, 1'b1, 8'h00, 8'h00, 16'h0100, 16'h0000,
                          16'hffff, 16'h0000, 16'h0000, 8'hff));
        // input: B wraps to FF, C-1 plus data carries, PC wraps
        send_step(step_of(OP_IN, 1'b1, 1'b1, 8'hff, 8'hff, 16'h0000, 16'hffff,
                          16'h0000, 16'h0000, 16'hffff, 8'h01));
        send_step(step_of(OP_IN, 1'b0, 1'b1, 8'h5a, 8'h5a, 16'hffff, 16'h1234,
                          16'h8000, 16'h0002, 16'h1234, 8'h80));
        send_step(step_of(OP_IN, 1'b1, 1'b0, 8'ha5, 8'ha5, 16'h0200, 16'h4321,
                          16'h7fff, 16'hffff, 16'h0001, 8'h00));
        // output: new L is zero
        send_step(step_of(OP_OUT, 1'b0, 1'b1, 8'h00, 8'hff, 16'h0100, 16'h0000,
                          16'h00ff, 16'h0100, 16'h0000, 8'h01));
        // output: L wraps to FF and carries, B wraps
        send_step(step_of(OP_OUT, 1'b1, 1'b1, 8'hff, 8'h00, 16'h0000, 16'hffff,
                          16'h0000, 16'h0001, 16'hffff, 8'hff));
        send_step(step_of(OP_OUT, 1'b0, 1'b1, 8'h33, 8'h33, 16'h8001, 16'h8888,
                          16'hfffe, 16'h0000, 16'h7777, 8'h80));
        send_step(step_of(OP_OUT, 1'b1, 1'b0, 8'hcc, 8'hff, 16'hffff, 16'h0101,
                          16'h1234, 16'hfffe, 16'h8000, 8'h00));
    endtask

    task automatic test_random_mix(input int send_pct, input int recv_pct,
                                   input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_step(rand_step());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_move_edges();
        test_compare_edges();
        test_io_edges();
        test_random_mix(37, 79, RandomSteps);
        test_random_mix(79, 37, RandomSteps);
        test_random_mix(0, 0, RandomSteps);
        s_axis_tvalid <= 1'b0;
        while (steps_checked < steps_sent) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (predicted_steps.size() != 0) begin
            error_count++;
            $display("%0d predicted results never arrived", predicted_steps.size());
        end
        $display("checked %0d steps: %0d move, %0d compare, %0d in, %0d out",
                 steps_checked, kind_count[OP_MOVE], kind_count[OP_COMPARE],
                 kind_count[OP_IN], kind_count[OP_OUT]);
        $display("%0d repeating steps rewound PC, %0d field mismatches",
                 rewind_count, error_count);
        if (error_count == 0) begin
            $display("block_move_compare_io_step regression: pass");
        end else begin
            $display("block_move_compare_io_step regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/bmc_pkg.sv
design/bmc_in_reg.sv
design/bmc_step.sv
design/bmc_out_reg.sv
design/block_move_compare_io_step.sv
verif/tb_top.sv
